### hw/rtl/key_binding_repeat_qualifier_assert.svh
// Assertion macros for the key binding repeat qualifier checks
`ifndef KEY_BINDING_REPEAT_QUALIFIER_ASSERT_SVH
`define KEY_BINDING_REPEAT_QUALIFIER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KBRQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key binding qualifier check failed");

// next-cycle implication, checked out of reset
`define KBRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key binding qualifier check failed");

`endif

### hw/rtl/kbrq_pkg.sv
// Package: shared types and constants of the key binding repeat qualifier
package kbrq_pkg;

  localparam int TIME_W  = 20;
  localparam int TIMER_W = 32;
  localparam int INDEX_W = 3;

  localparam logic [TIME_W-1:0] REPEAT_INTERVAL_RESET = 20'd100000;
  localparam logic [TIME_W-1:0] INITIAL_PAUSE_RESET   = 20'd500000;

  typedef enum logic [INDEX_W-1:0] {
    REG_MODIFIER_RULE      = 3'd0,
    REG_TRIGGER_BOUND      = 3'd1,
    REG_HOLD_KEYS_USED     = 3'd2,
    REG_REPEAT_INTERVAL_US = 3'd3,
    REG_INITIAL_PAUSE_US   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]        modifier_rule;
    logic              trigger_bound;
    logic [1:0]        hold_keys_used;
    logic [TIME_W-1:0] repeat_interval_us;
    logic [TIME_W-1:0] initial_pause_us;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic holds_ok;
    logic down;
    logic pressed;
  } frame_ctrl_t;

endpackage

### hw/rtl/kbrq_cfg.sv
// Configuration register file of the key binding repeat qualifier
module kbrq_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [kbrq_pkg::INDEX_W-1:0]      cfg_index,
  input  logic [kbrq_pkg::TIME_W-1:0]       cfg_data,
  output kbrq_pkg::cfg_t                    cfg
);

  kbrq_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.modifier_rule      <= '0;
      regs.trigger_bound      <= 1'b0;
      regs.hold_keys_used     <= '0;
      regs.repeat_interval_us <= kbrq_pkg::REPEAT_INTERVAL_RESET;
      regs.initial_pause_us   <= kbrq_pkg::INITIAL_PAUSE_RESET;
    end else if (cfg_write) begin
      unique case (kbrq_pkg::cfg_reg_t'(cfg_index))
        kbrq_pkg::REG_MODIFIER_RULE:      regs.modifier_rule      <= cfg_data[7:0];
        kbrq_pkg::REG_TRIGGER_BOUND:      regs.trigger_bound      <= cfg_data[0];
        kbrq_pkg::REG_HOLD_KEYS_USED:     regs.hold_keys_used     <= cfg_data[1:0];
        kbrq_pkg::REG_REPEAT_INTERVAL_US: regs.repeat_interval_us <= cfg_data;
        kbrq_pkg::REG_INITIAL_PAUSE_US:   regs.initial_pause_us   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

### hw/rtl/kbrq_typematic.sv
// One typematic repeat channel: held flag, countdown timer and hit decision
module kbrq_typematic (
  input  logic                        clk,
  input  logic                        rst,
  input  kbrq_pkg::frame_ctrl_t       ctrl,
  input  logic [kbrq_pkg::TIME_W-1:0] elapsed_us,
  input  logic [kbrq_pkg::TIME_W-1:0] start_us,
  input  logic [kbrq_pkg::TIME_W-1:0] interval_us,
  output logic                        hit
);

  localparam int EXT_W = kbrq_pkg::TIMER_W - kbrq_pkg::TIME_W;

  logic                               held;
  logic                               held_next;
  logic signed [kbrq_pkg::TIMER_W-1:0] countdown;
  logic signed [kbrq_pkg::TIMER_W-1:0] countdown_next;
  logic signed [kbrq_pkg::TIMER_W-1:0] diff;
  logic signed [kbrq_pkg::TIMER_W-1:0] elapsed_ext;
  logic signed [kbrq_pkg::TIMER_W-1:0] interval_ext;
  logic signed [kbrq_pkg::TIMER_W-1:0] start_ext;

  assign elapsed_ext  = $signed({{EXT_W{1'b0}}, elapsed_us});
  assign interval_ext = $signed({{EXT_W{1'b0}}, interval_us});
  assign start_ext    = $signed({{EXT_W{1'b0}}, start_us});
  assign diff         = countdown - elapsed_ext;

  always_comb begin
    hit            = 1'b0;
    held_next      = held;
    countdown_next = countdown;
    if (ctrl.active) begin
      if (held) begin
        if (ctrl.holds_ok && ctrl.down) begin
          if (diff[kbrq_pkg::TIMER_W-1] || (diff == '0)) begin
            countdown_next = diff + interval_ext;
            hit            = 1'b1;
          end else begin
            countdown_next = diff;
          end
        end else begin
          held_next = 1'b0;
        end
      end else if (ctrl.holds_ok && ctrl.pressed) begin
        held_next      = 1'b1;
        countdown_next = start_ext;
        hit            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      countdown <= '0;
    end else begin
      held      <= held_next;
      countdown <= countdown_next;
    end
  end

endmodule

### hw/rtl/key_binding_repeat_qualifier.sv
// Top level: key binding repeat qualifier, input register, flag logic, result register
// One word in is one frame, one word out is its five flags. A frame is taken
// into the input register, then qualified and timed as it moves on to the result
// register, and one frame is accepted per cycle while the output side keeps taking
// words. The timer update of both typematic channels in that step sets that rate.
// Configuration must be written only while no frame is in flight; the user is
// bound by this, and the block itself does not enforce it.
module key_binding_repeat_qualifier (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [kbrq_pkg::INDEX_W-1:0] cfg_index,
  input  logic [kbrq_pkg::TIME_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  modifier_keys,
  input  logic                        trigger_down,
  input  logic [1:0]                  hold_keys_down,
  input  logic [kbrq_pkg::TIME_W-1:0] elapsed_us,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        once_hit,
  output logic                        hold_hit,
  output logic                        release_hit,
  output logic                        repeat_hit,
  output logic                        delay_hit
);

  kbrq_pkg::cfg_t        cfg;
  kbrq_pkg::frame_ctrl_t ctrl;

  logic                        s1_valid;
  logic [2:0]                  s1_mods;
  logic                        s1_down;
  logic [1:0]                  s1_holds;
  logic [kbrq_pkg::TIME_W-1:0] s1_elapsed;
  logic                        advance;
  logic                        trigger_was_down;
  logic [3:0]                  mod_mask;
  logic                        matched;
  logic                        holds_ok;
  logic                        rep_hit;
  logic                        dly_hit;

  kbrq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mods    <= modifier_keys;
      s1_down    <= trigger_down;
      s1_holds   <= hold_keys_down;
      s1_elapsed <= elapsed_us;
    end
  end

  assign mod_mask = ~cfg.modifier_rule[7:4];
  assign matched  = cfg.trigger_bound &&
                    ((cfg.modifier_rule[3:0] & mod_mask) == ({1'b0, s1_mods} & mod_mask));
  assign holds_ok = (s1_holds & cfg.hold_keys_used) == cfg.hold_keys_used;

  assign ctrl.active   = advance && matched;
  assign ctrl.holds_ok = holds_ok;
  assign ctrl.down     = s1_down;
  assign ctrl.pressed  = s1_down && !trigger_was_down;

  kbrq_typematic u_repeat (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .elapsed_us  (s1_elapsed),
    .start_us    (cfg.repeat_interval_us),
    .interval_us (cfg.repeat_interval_us),
    .hit         (rep_hit)
  );

  kbrq_typematic u_delay (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .elapsed_us  (s1_elapsed),
    .start_us    (cfg.initial_pause_us),
    .interval_us (cfg.repeat_interval_us),
    .hit         (dly_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_was_down <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (advance) begin
        trigger_was_down <= s1_down;
        out_valid        <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      once_hit    <= matched && holds_ok && ctrl.pressed;
      hold_hit    <= matched && holds_ok && s1_down;
      release_hit <= matched && (s1_down ? !holds_ok : trigger_was_down);
      repeat_hit  <= rep_hit;
      delay_hit   <= dly_hit;
    end
  end

endmodule

### hw/rtl/kbrq_checker.sv
// Port-level checker of the key binding repeat qualifier, with its bind
`include "key_binding_repeat_qualifier_assert.svh"

module kbrq_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic once_hit,
  input logic hold_hit,
  input logic release_hit,
  input logic repeat_hit,
  input logic delay_hit
);

  `KBRQ_ASSERT_NEXT(a_out_word_held, out_valid && out_stall, out_valid)
  `KBRQ_ASSERT_NEXT(a_out_word_stable, out_valid && out_stall,
                    $stable({once_hit, hold_hit, release_hit, repeat_hit, delay_hit}))
  `KBRQ_ASSERT_NOW(a_hold_release_excl, out_valid, !(hold_hit && release_hit))
  `KBRQ_ASSERT_NOW(a_once_implies_hold, out_valid && once_hit, hold_hit)

endmodule

bind key_binding_repeat_qualifier kbrq_checker u_checker (.*);
